/* hw/rtl/rfifo_pkg.sv */
// Shared constants and codes for the ring FIFO block.
`timescale 1ns / 1ps
`default_nettype none
package rfifo_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = 7;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 7;

    localparam logic [1:0] MODE_PUT     = 2'd0;
    localparam logic [1:0] MODE_GET     = 2'd1;
    localparam logic [1:0] MODE_PEEK    = 2'd2;
    localparam logic [1:0] MODE_DISCARD = 2'd3;

    localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

endpackage
`default_nettype wire

/* hw/rtl/rfifo_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rfifo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/ring_fifo_burst_put_get_peek.sv */
// Top level of the ring FIFO with burst put, get, peek and discard.
//
// Input stream: tuser selects put, get, peek or discard; tlast marks the end
// of a put run; tdata carries the word to store and the request count.
// Output stream: one transaction per returned word, or one status
// transaction for a closing put, a discard or an empty get/peek.
// A put run is accepted at one word per cycle while the output register is
// empty or being drained. A get or peek of n words blocks the input until
// its last word is loaded; after a setup state the single RAM read port
// streams one word per cycle through its read register into the output
// register while the receiver keeps up. A discard or an empty request is
// answered in the next cycle. Results sit in an output register; the input
// is taken while that register is empty or being drained. When the receiver
// stalls, reads pause and nothing is lost.
// Reset clears both pointers and the run counter, so the buffer starts
// empty; the storage itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module ring_fifo_burst_put_get_peek
    import rfifo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // word_in[31:0], request_count[38:32], zero
    input  wire logic        s_axis_tlast,   // run_last
    input  wire logic [1:0]  s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,   // word_out[31:0], done_count[38:32], zero
    output logic             m_axis_tlast,   // last
    output logic             m_axis_tuser    // word_valid
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic              state_reg, state_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  run_cnt_reg, run_cnt_next;
    logic [PTR_W-1:0]  seq_ptr_reg, seq_ptr_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              rd_last_reg, rd_last_next;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_word_reg, out_word_next;
    logic              out_wv_reg, out_wv_next;
    logic [CNT_W-1:0]  out_done_reg, out_done_next;
    logic              out_last_reg, out_last_next;

    logic [1:0]        mode;
    logic [WORD_W-1:0] word_in;
    logic [CNT_W-1:0]  req;
    logic              accept;
    logic [PTR_W-1:0]  fill;
    logic [CNT_W-1:0]  n;
    logic              out_free;
    logic              load;
    logic              issue;
    logic              ram_we;
    logic [WORD_W-1:0] ram_rdata;

    assign mode    = s_axis_tuser;
    assign word_in = s_axis_tdata[31:0];
    assign req     = s_axis_tdata[38:32];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign fill = wr_ptr_reg - rd_ptr_reg;
    assign n    = (req < fill) ? req : fill;

    assign ram_we = accept && (mode == MODE_PUT) && (fill < PTR_DEPTH);
    assign load   = rd_pend_reg && out_free;
    assign issue  = (state_reg == ST_BUSY) && (remain_reg != '0)
                    && (!rd_pend_reg || load);

    rfifo_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg[ADDR_W-1:0]),
        .wdata (word_in),
        .re    (issue),
        .raddr (seq_ptr_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        run_cnt_next   = run_cnt_reg;
        seq_ptr_next   = seq_ptr_reg;
        remain_next    = remain_reg;
        total_next     = total_reg;
        rd_pend_next   = rd_pend_reg;
        rd_last_next   = rd_last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_word_next  = out_word_reg;
        out_wv_next    = out_wv_reg;
        out_done_next  = out_done_reg;
        out_last_next  = out_last_reg;

        if (accept)
        begin
            case (mode)
                MODE_PUT:
                begin
                    if (ram_we)
                    begin
                        wr_ptr_next = wr_ptr_reg + 1'b1;
                        if (run_cnt_reg != CNT_MAX)
                        begin
                            run_cnt_next = run_cnt_reg + 1'b1;
                        end
                    end
                    if (s_axis_tlast)
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = '0;
                        out_wv_next    = 1'b0;
                        out_done_next  = run_cnt_next;
                        out_last_next  = 1'b1;
                        run_cnt_next   = '0;
                    end
                end
                MODE_DISCARD:
                begin
                    rd_ptr_next    = rd_ptr_reg + n;
                    out_valid_next = 1'b1;
                    out_word_next  = '0;
                    out_wv_next    = 1'b0;
                    out_done_next  = n;
                    out_last_next  = 1'b1;
                end
                default:
                begin
                    if (n == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = '0;
                        out_wv_next    = 1'b0;
                        out_done_next  = '0;
                        out_last_next  = 1'b1;
                    end
                    else
                    begin
                        state_next   = ST_BUSY;
                        seq_ptr_next = rd_ptr_reg;
                        remain_next  = n;
                        total_next   = n;
                        if (mode == MODE_GET)
                        begin
                            rd_ptr_next = rd_ptr_reg + n;
                        end
                    end
                end
            endcase
        end

        if (load)
        begin
            out_valid_next = 1'b1;
            out_word_next  = ram_rdata;
            out_wv_next    = 1'b1;
            out_done_next  = total_reg;
            out_last_next  = rd_last_reg;
            rd_pend_next   = 1'b0;
            if (rd_last_reg)
            begin
                state_next = ST_IDLE;
            end
        end

        if (issue)
        begin
            rd_pend_next = 1'b1;
            rd_last_next = (remain_reg == CNT_W'(1));
            seq_ptr_next = seq_ptr_reg + 1'b1;
            remain_next  = remain_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            run_cnt_reg   <= '0;
            remain_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            run_cnt_reg   <= run_cnt_next;
            remain_reg    <= remain_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_ptr_reg  <= seq_ptr_next;
        total_reg    <= total_next;
        rd_last_reg  <= rd_last_next;
        out_word_reg <= out_word_next;
        out_wv_reg   <= out_wv_next;
        out_done_reg <= out_done_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_done_reg, out_word_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_wv_reg;

endmodule
`default_nettype wire
